[hdl/iss_pkg.sv]
// Shared types and constants for the interval sample statistics block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package iss_pkg;

    localparam int SAMPLE_W        = 32;
    localparam int PEAK_W          = 31;
    localparam int ACTION_W        = 2;
    localparam int DEF_MAX_RECORDS = 64;

    // Command codes carried in the action field
    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD     = 2'd0,
        ACT_ADVANCE = 2'd1,
        ACT_CLEAR   = 2'd2
    } action_t;

    // Status returned by the serial divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[hdl/iss_ifs.sv]
// Valid/ready channel interfaces for command and result words.
// Depends on iss_pkg for field widths.
`default_nettype none

interface iss_cmd_if
    import iss_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [ACTION_W-1:0]        action;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, action, sample, input ready);
    modport sink   (input valid, action, sample, output ready);
endinterface

interface iss_res_if
    import iss_pkg::*;
#(
    parameter int CNT_W = 7
) ();
    logic                       valid;
    logic                       ready;
    logic                       accepted;
    logic [CNT_W-1:0]           sample_count;
    logic signed [SAMPLE_W-1:0] mean_value;
    logic [PEAK_W-1:0]          max_value;

    modport source (output valid, accepted, sample_count, mean_value, max_value,
                    input ready);
    modport sink   (input valid, accepted, sample_count, mean_value, max_value,
                    output ready);
endinterface

`default_nettype wire

[hdl/iss_divider.sv]
// Bit-serial restoring divider: one quotient bit per cycle, unsigned operands.
// Depends on iss_pkg for the status struct.
`default_nettype none

module iss_divider
    import iss_pkg::*;
#(
    parameter int SUM_W = 38,
    parameter int CNT_W = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [SUM_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic      [SUM_W-1:0] quotient,
    output div_stat_t             stat
);

    localparam int STEP_W = $clog2(SUM_W + 1);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [SUM_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;

    logic [CNT_W:0]    rem_shift;
    logic [CNT_W:0]    rem_diff;
    logic              fits;
    logic              busy;

    assign busy = (step_reg != '0);

    // One restoring step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[SUM_W-1]};
        rem_diff  = rem_shift - {1'b0, dvs_reg};
        fits      = (rem_shift >= {1'b0, dvs_reg});
    end

    always_comb
    begin
        step_next = step_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            step_next = STEP_W'(SUM_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy)
        begin
            step_next = step_reg - STEP_W'(1);
            done_next = (step_reg == STEP_W'(1));
            quo_next  = {quo_reg[SUM_W-2:0], fits};
            rem_next  = fits ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy;
    assign stat.done = done_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy)
        else $error("divider started while busy");

    a_start_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (divisor != '0))
        else $error("divider started with zero divisor");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (rem_reg < dvs_reg))
        else $error("partial remainder not below divisor");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy))
        else $error("divider done without a preceding step");

endmodule

`default_nettype wire

[hdl/interval_sample_statistics.sv]
// Interval sample statistics, top level.
// Depends on iss_pkg, the channel interfaces in iss_ifs and iss_divider.
//
// Usage: each command word (action, sample) on cmd yields one result word on
// result: accepted flag, sample count, mean (truncated toward zero, 0 when
// empty) and maximum (floor 0). Add stores a sample unless MAX_RECORDS are
// held; advance keeps only the newest sample; clear empties everything.
// A command is taken when cmd.ready is high, which is only while no earlier
// command is in progress. State is updated in the cycle of acceptance; the
// mean then comes from a bit-serial divider that steps through the bits of
// the running sum (32 + log2(MAX_RECORDS) bits, 38 at the default).
// After acceptance the word passes through the load, divide and finish steps
// to the output register; the divide step is skipped when the interval is
// empty. A new command is not taken until the previous word has left the
// finish step for the output register.
// The result sits in an output register: the next command is taken while it
// waits. If the receiver stalls still longer, the finished word waits in the
// last step until the register frees, and cmd.ready stays low meanwhile.
// Reset (rst_n, asynchronous, active low) empties the interval and drops
// any word in flight.
`default_nettype none

module interval_sample_statistics
    import iss_pkg::*;
#(
    parameter int MAX_RECORDS = DEF_MAX_RECORDS,
    parameter int CNT_W       = $clog2(MAX_RECORDS + 1)
) (
    input  wire logic clk,
    input  wire logic rst_n,
    iss_cmd_if.sink   cmd,
    iss_res_if.source result
);

    localparam int SUM_W = SAMPLE_W + $clog2(MAX_RECORDS);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOAD   = 4'b0010,
        S_DIVIDE = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [PEAK_W-1:0]          peak_reg, peak_next;
    logic signed [SAMPLE_W-1:0] newest_reg, newest_next;
    logic                       ok_reg, ok_next;

    logic                       out_valid_reg, out_valid_next;
    logic                       out_ok_reg, out_ok_next;
    logic [CNT_W-1:0]           out_count_reg, out_count_next;
    logic signed [SAMPLE_W-1:0] out_mean_reg, out_mean_next;
    logic [PEAK_W-1:0]          out_peak_reg, out_peak_next;

    logic                       take;
    logic                       out_free;
    logic                       div_start;
    logic [SUM_W-1:0]           div_dividend;
    logic [SUM_W-1:0]           div_quotient;
    div_stat_t                  div_stat;
    logic [SAMPLE_W-1:0]        quo_low;

    assign take     = cmd.valid && cmd.ready;
    assign out_free = !out_valid_reg || result.ready;

    // Command decode and interval state update
    always_comb
    begin
        count_next  = count_reg;
        sum_next    = sum_reg;
        peak_next   = peak_reg;
        newest_next = newest_reg;
        ok_next     = ok_reg;
        if (take)
        begin
            ok_next = 1'b1;
            unique case (action_t'(cmd.action))
                ACT_ADD:
                begin
                    if (count_reg >= CNT_W'(MAX_RECORDS))
                    begin
                        ok_next = 1'b0;
                    end
                    else
                    begin
                        count_next  = count_reg + CNT_W'(1);
                        sum_next    = sum_reg + SUM_W'(cmd.sample);
                        newest_next = cmd.sample;
                        if (!cmd.sample[SAMPLE_W-1] && (cmd.sample[PEAK_W-1:0] > peak_reg))
                        begin
                            peak_next = cmd.sample[PEAK_W-1:0];
                        end
                    end
                end
                ACT_ADVANCE:
                begin
                    if (count_reg != '0)
                    begin
                        count_next = CNT_W'(1);
                        sum_next   = SUM_W'(newest_reg);
                        peak_next  = newest_reg[SAMPLE_W-1] ? '0 : newest_reg[PEAK_W-1:0];
                    end
                    else
                    begin
                        sum_next    = '0;
                        peak_next   = '0;
                        newest_next = '0;
                    end
                end
                ACT_CLEAR:
                begin
                    count_next  = '0;
                    sum_next    = '0;
                    peak_next   = '0;
                    newest_next = '0;
                end
                default:
                begin
                    ok_next = 1'b1;
                end
            endcase
        end
    end

    // Sequencer: accept, start divide (skipped when empty), wait, hand over to output register
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (count_reg != '0)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIVIDE;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Magnitude of the sum for the divider; sign restored at the end
    assign div_dividend = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign quo_low      = div_quotient[SAMPLE_W-1:0];

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_count_next = out_count_reg;
        out_mean_next  = out_mean_reg;
        out_peak_next  = out_peak_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_FINISH) && out_free)
        begin
            out_valid_next = 1'b1;
            out_ok_next    = ok_reg;
            out_count_next = count_reg;
            out_peak_next  = peak_reg;
            if (count_reg == '0)
            begin
                out_mean_next = '0;
            end
            else if (sum_reg[SUM_W-1])
            begin
                out_mean_next = -quo_low;
            end
            else
            begin
                out_mean_next = quo_low;
            end
        end
    end

    iss_divider #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (count_reg),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // Control and interval state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sum_reg       <= '0;
            peak_reg      <= '0;
            newest_reg    <= '0;
            ok_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            peak_reg      <= peak_next;
            newest_reg    <= newest_next;
            ok_reg        <= ok_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result word payload
    always_ff @(posedge clk)
    begin
        out_ok_reg    <= out_ok_next;
        out_count_reg <= out_count_next;
        out_mean_reg  <= out_mean_next;
        out_peak_reg  <= out_peak_next;
    end

    assign cmd.ready           = (state_reg == S_IDLE);
    assign result.valid        = out_valid_reg;
    assign result.accepted     = out_ok_reg;
    assign result.sample_count = out_count_reg;
    assign result.mean_value   = out_mean_reg;
    assign result.max_value    = out_peak_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RECORDS))
        else $error("held count above capacity");

    a_refusal_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ok_reg) |-> (out_count_reg == CNT_W'(MAX_RECORDS)))
        else $error("refused word while interval not full");

    a_idle_div_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !div_stat.busy)
        else $error("divider busy while idle");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FINISH) && out_free) |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("finished word not loaded into output register");

endmodule

`default_nettype wire
